/* rtl/core/page_ownership_map_checker_defines.svh */
// Assertion helpers for the page ownership map checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PAGE_OWNERSHIP_MAP_CHECKER_DEFINES_SVH
`define PAGE_OWNERSHIP_MAP_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define POMC_CHECK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page ownership map checker: check failed");

// Next-cycle implication, disabled while in reset
`define POMC_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page ownership map checker: check failed");

`endif

/* rtl/core/pomc_pkg.sv */
package pomc_pkg;

	// Default sizing of the block
	localparam int unsigned MAP_PAGES_DEF   = 65536;
	localparam int unsigned OWNER_SLOTS_DEF = 64;
	localparam int unsigned MAX_RUN_DEF     = 64;

	// Smallest legal header, in bytes
	localparam int unsigned LONG_BYTES = 8;

	// Field widths
	localparam int unsigned PAGE_W    = 32;
	localparam int unsigned RUN_W     = 7;
	localparam int unsigned OWNER_W   = 6;
	localparam int unsigned PAY_W     = 22;
	localparam int unsigned HDR_W     = 16;
	localparam int unsigned CFG_W     = 17;
	localparam int unsigned CNT_W     = 17;
	localparam int unsigned BYTE_W    = 48;
	localparam int unsigned TOT_W     = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'b1;

	// Register reset values
	localparam logic [CFG_W-1:0] PAGE_SIZE_RST  = 17'd4096;
	localparam logic [CFG_W-1:0] PAGE_LIMIT_RST = 17'd65536;

	// Per-page outcome
	typedef enum logic [1:0] {
		PAGE_CLAIMED = 2'd0,
		PAGE_RANGE   = 2'd1,
		PAGE_OWNED   = 2'd2
	} page_stat_t;

	// Per-run size check outcome
	typedef enum logic [1:0] {
		SIZE_GOOD    = 2'd0,
		SIZE_BAD_HDR = 2'd1,
		SIZE_EMPTY   = 2'd2,
		SIZE_OVER    = 2'd3
	} size_stat_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic load;
		logic check;
		logic page_rd;
		logic emit;
	} pomc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic run_zero;
		logic last_page;
	} pomc_stat_t;

endpackage

/* rtl/core/pomc_ctrl.sv */
module pomc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pomc_pkg::pomc_cmd_t    cmd,
	input  pomc_pkg::pomc_stat_t   stat
);

	typedef enum logic [5:0] {
		ST_CLEAR   = 6'b000001,
		ST_IDLE    = 6'b000010,
		ST_LOAD    = 6'b000100,
		ST_CHECK   = 6'b001000,
		ST_PAGE_RD = 6'b010000,
		ST_PAGE_WB = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// Output register can take a new beat
	assign out_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && !stat.run_zero) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_PAGE_RD;
			end
			ST_PAGE_RD: begin
				cmd.page_rd = 1'b1;
				state_d     = ST_PAGE_WB;
			end
			ST_PAGE_WB: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.last_page ? ST_IDLE : ST_PAGE_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Result beat pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* rtl/core/pomc_datapath.sv */
module pomc_datapath #(
	parameter int unsigned MAP_PAGES   = pomc_pkg::MAP_PAGES_DEF,
	parameter int unsigned OWNER_SLOTS = pomc_pkg::OWNER_SLOTS_DEF,
	parameter int unsigned MAX_RUN     = pomc_pkg::MAX_RUN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pomc_pkg::pomc_cmd_t               cmd,
	output pomc_pkg::pomc_stat_t              stat,
	// configuration
	input  logic                              cfg_valid,
	input  logic [pomc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pomc_pkg::CFG_W-1:0]        cfg_data,
	// input item
	input  logic [pomc_pkg::PAGE_W-1:0]       first_page,
	input  logic [pomc_pkg::RUN_W-1:0]        page_run,
	input  logic [pomc_pkg::OWNER_W-1:0]      owner_index,
	input  logic [pomc_pkg::PAY_W-1:0]        payload_size,
	input  logic [pomc_pkg::HDR_W-1:0]        header_size,
	// result item
	output logic [pomc_pkg::PAGE_W-1:0]       page_number,
	output logic [1:0]                        page_status,
	output logic [pomc_pkg::OWNER_W-1:0]      prior_owner,
	output logic [1:0]                        size_status,
	output logic [pomc_pkg::CNT_W-1:0]        owner_page_count,
	output logic [pomc_pkg::BYTE_W-1:0]       owner_byte_sum,
	output logic [pomc_pkg::TOT_W-1:0]        visited_pages,
	output logic [pomc_pkg::BYTE_W-1:0]       visited_bytes,
	output logic                              run_end
);

	localparam int unsigned PAGE_W  = pomc_pkg::PAGE_W;
	localparam int unsigned RUN_W   = pomc_pkg::RUN_W;
	localparam int unsigned OWNER_W = pomc_pkg::OWNER_W;
	localparam int unsigned PAY_W   = pomc_pkg::PAY_W;
	localparam int unsigned HDR_W   = pomc_pkg::HDR_W;
	localparam int unsigned CFG_W   = pomc_pkg::CFG_W;
	localparam int unsigned CNT_W   = pomc_pkg::CNT_W;
	localparam int unsigned BYTE_W  = pomc_pkg::BYTE_W;
	localparam int unsigned TOT_W   = pomc_pkg::TOT_W;
	localparam int unsigned RB_W    = PAY_W + 1;
	localparam int unsigned PROD_W  = RUN_W + CFG_W;
	localparam int unsigned MAP_W   = $clog2(MAP_PAGES);
	localparam int unsigned SLOT_W  = $clog2(OWNER_SLOTS);
	localparam int unsigned CLR_LEN = (MAP_PAGES > OWNER_SLOTS) ? MAP_PAGES : OWNER_SLOTS;
	localparam int unsigned CLR_W   = $clog2(CLR_LEN);
	localparam int unsigned CLR_CW  = CLR_W + 1;
	localparam int unsigned OWN_N   = 1 << OWNER_W;

	// Storage
	logic [OWNER_W-1:0] map_mem    [0:MAP_PAGES-1];
	logic [CNT_W-1:0]   opages_mem [0:OWNER_SLOTS-1];
	logic [BYTE_W-1:0]  obytes_mem [0:OWNER_SLOTS-1];

	// Owner index reduced to the slot range, worked out at elaboration
	logic [OWNER_W-1:0] owner_mod [0:OWN_N-1];
	for (genvar gi = 0; gi < OWN_N; gi++) begin : g_owner_mod
		assign owner_mod[gi] = OWNER_W'(gi % OWNER_SLOTS);
	end

	logic [CFG_W-1:0]   page_size_q;
	logic [CFG_W-1:0]   page_limit_q;
	logic [CLR_W-1:0]   clr_q;
	logic [PAGE_W-1:0]  page_cur_q;
	logic [RUN_W-1:0]   run_q;
	logic [RUN_W-1:0]   rem_q;
	logic [OWNER_W-1:0] owner_q;
	logic [PAY_W-1:0]   payload_q;
	logic [HDR_W-1:0]   header_q;
	logic [PROD_W-1:0]  prod_q;
	logic [CNT_W-1:0]   opages_rd_q;
	logic [BYTE_W-1:0]  obytes_rd_q;
	logic [CNT_W-1:0]   opages_q;
	logic [BYTE_W-1:0]  obytes_q;
	logic [TOT_W-1:0]   page_total_q;
	logic [BYTE_W-1:0]  byte_total_q;
	logic [1:0]         size_q;
	logic [OWNER_W-1:0] map_rd_q;

	logic [RUN_W-1:0]   run_cut;
	logic [SLOT_W-1:0]  slot;
	logic               clr_in_map;
	logic               clr_in_slots;
	logic [TOT_W:0]     ptot_sum;
	logic [RB_W-1:0]    run_bytes;
	logic               hdr_bad;
	logic [1:0]         size_d;
	logic [BYTE_W:0]    obytes_sum;
	logic [BYTE_W:0]    btot_sum;
	logic [BYTE_W-1:0]  obytes_sat;
	logic [BYTE_W-1:0]  btot_sat;
	logic               in_range;
	logic               claim;
	logic [1:0]         pstat_d;
	logic [CNT_W-1:0]   opages_inc;

	// Run length cut to the longest run handled
	assign run_cut = (page_run > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : page_run;
	assign slot    = SLOT_W'(owner_q);

	// Clearing sweep bookkeeping
	assign clr_in_map   = CLR_CW'(clr_q) < CLR_CW'(MAP_PAGES);
	assign clr_in_slots = CLR_CW'(clr_q) < CLR_CW'(OWNER_SLOTS);

	assign stat.clr_last  = (clr_q == CLR_W'(CLR_LEN - 1));
	assign stat.run_zero  = (page_run == '0);
	assign stat.last_page = (rem_q == RUN_W'(1));

	// Run totals
	assign ptot_sum  = (TOT_W+1)'(page_total_q) + (TOT_W+1)'(run_q);
	assign run_bytes = RB_W'(payload_q) + RB_W'(header_q);

	// Size check, bad header first, then empty payload, then overflow
	assign hdr_bad = (header_q < HDR_W'(pomc_pkg::LONG_BYTES)) ||
		((CFG_W'(header_q) + CFG_W'(pomc_pkg::LONG_BYTES)) >= page_size_q);

	always_comb begin
		if (hdr_bad) begin
			size_d = pomc_pkg::SIZE_BAD_HDR;
		end else if (payload_q == '0) begin
			size_d = pomc_pkg::SIZE_EMPTY;
		end else if (PROD_W'(run_bytes) > prod_q) begin
			size_d = pomc_pkg::SIZE_OVER;
		end else begin
			size_d = pomc_pkg::SIZE_GOOD;
		end
	end

	// Saturating byte sums
	assign obytes_sum = (BYTE_W+1)'(obytes_rd_q) + (BYTE_W+1)'(run_bytes);
	assign btot_sum   = (BYTE_W+1)'(byte_total_q) + (BYTE_W+1)'(run_bytes);
	assign obytes_sat = obytes_sum[BYTE_W] ? '1 : obytes_sum[BYTE_W-1:0];
	assign btot_sat   = btot_sum[BYTE_W] ? '1 : btot_sum[BYTE_W-1:0];

	// Per-page decision
	assign in_range = (page_cur_q < PAGE_W'(page_limit_q)) &&
		(page_cur_q < PAGE_W'(MAP_PAGES));
	assign opages_inc = (&opages_q) ? opages_q : opages_q + CNT_W'(1);

	always_comb begin
		if (!in_range) begin
			pstat_d = pomc_pkg::PAGE_RANGE;
		end else if (map_rd_q != '0) begin
			pstat_d = pomc_pkg::PAGE_OWNED;
		end else begin
			pstat_d = pomc_pkg::PAGE_CLAIMED;
		end
	end
	assign claim = (pstat_d == pomc_pkg::PAGE_CLAIMED);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q  <= pomc_pkg::PAGE_SIZE_RST;
			page_limit_q <= pomc_pkg::PAGE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pomc_pkg::CFG_PAGE_SIZE:  page_size_q  <= cfg_data;
				pomc_pkg::CFG_PAGE_LIMIT: page_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && !stat.clr_last) begin
			clr_q <= clr_q + CLR_W'(1);
		end
	end

	// Running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_total_q <= '0;
			byte_total_q <= '0;
		end else begin
			if (cmd.load) begin
				page_total_q <= ptot_sum[TOT_W] ? '1 : ptot_sum[TOT_W-1:0];
			end
			if (cmd.check && (size_d == pomc_pkg::SIZE_GOOD)) begin
				byte_total_q <= btot_sat;
			end
		end
	end

	// Item capture and per-run working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_cur_q <= first_page;
			run_q      <= run_cut;
			owner_q    <= owner_mod[owner_index];
			payload_q  <= payload_size;
			header_q   <= header_size;
		end
		if (cmd.load) begin
			prod_q <= PROD_W'(run_q) * PROD_W'(page_size_q);
			rem_q  <= run_q;
		end
		if (cmd.check) begin
			size_q   <= size_d;
			opages_q <= opages_rd_q;
			obytes_q <= (size_d == pomc_pkg::SIZE_GOOD) ? obytes_sat : obytes_rd_q;
		end
		if (cmd.emit) begin
			page_cur_q <= page_cur_q + PAGE_W'(1);
			rem_q      <= rem_q - RUN_W'(1);
			if (claim) begin
				opages_q <= opages_inc;
			end
		end
	end

	// Owner map: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step && clr_in_map) begin
			map_mem[clr_q[MAP_W-1:0]] <= '0;
		end else if (cmd.emit && claim) begin
			map_mem[page_cur_q[MAP_W-1:0]] <= owner_q;
		end
		if (cmd.page_rd) begin
			map_rd_q <= map_mem[page_cur_q[MAP_W-1:0]];
		end
	end

	// Owner page counts
	always_ff @(posedge clk) begin
		if (cmd.clr_step && clr_in_slots) begin
			opages_mem[clr_q[SLOT_W-1:0]] <= '0;
		end else if (cmd.emit && claim) begin
			opages_mem[slot] <= opages_inc;
		end
		if (cmd.load) begin
			opages_rd_q <= opages_mem[slot];
		end
	end

	// Owner byte sums
	always_ff @(posedge clk) begin
		if (cmd.clr_step && clr_in_slots) begin
			obytes_mem[clr_q[SLOT_W-1:0]] <= '0;
		end else if (cmd.check && (size_d == pomc_pkg::SIZE_GOOD)) begin
			obytes_mem[slot] <= obytes_sat;
		end
		if (cmd.load) begin
			obytes_rd_q <= obytes_mem[slot];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			page_number      <= page_cur_q;
			page_status      <= pstat_d;
			prior_owner      <= (pstat_d == pomc_pkg::PAGE_OWNED) ? map_rd_q : '0;
			size_status      <= size_q;
			owner_page_count <= claim ? opages_inc : opages_q;
			owner_byte_sum   <= obytes_q;
			visited_pages    <= page_total_q;
			visited_bytes    <= byte_total_q;
			run_end          <= stat.last_page;
		end
	end

endmodule

/* rtl/core/page_ownership_map_checker.sv */
// Channel   Handshake              Carries
// in        in_valid / in_ready    first_page, page_run, owner_index, payload_size, header_size
// out       out_valid / out_ready  page_number .. run_end, one beat per page
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After reset a sweep over max(MAP_PAGES, OWNER_SLOTS) addresses (65536 by default) zeroes the
// owner map and owner counters; in_ready stays low meanwhile, cfg is taken at any time.
// After its accept, a run of pages holds in_ready low through the load and check states and
// then, for each page, a read then a write on the owner map; only then is the next run taken.
// A run of zero pages is taken without leaving the idle state and gives no beat.
// A result waits in the output register while out_ready is low; the next run may be
// accepted meanwhile, and page processing stalls only while a beat waits in the output register.
`include "page_ownership_map_checker_defines.svh"

module page_ownership_map_checker #(
	parameter int unsigned MAP_PAGES   = pomc_pkg::MAP_PAGES_DEF,
	parameter int unsigned OWNER_SLOTS = pomc_pkg::OWNER_SLOTS_DEF,
	parameter int unsigned MAX_RUN     = pomc_pkg::MAX_RUN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pomc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pomc_pkg::CFG_W-1:0]        cfg_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pomc_pkg::PAGE_W-1:0]       first_page,
	input  logic [pomc_pkg::RUN_W-1:0]        page_run,
	input  logic [pomc_pkg::OWNER_W-1:0]      owner_index,
	input  logic [pomc_pkg::PAY_W-1:0]        payload_size,
	input  logic [pomc_pkg::HDR_W-1:0]        header_size,
	// result items
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pomc_pkg::PAGE_W-1:0]       page_number,
	output logic [1:0]                        page_status,
	output logic [pomc_pkg::OWNER_W-1:0]      prior_owner,
	output logic [1:0]                        size_status,
	output logic [pomc_pkg::CNT_W-1:0]        owner_page_count,
	output logic [pomc_pkg::BYTE_W-1:0]       owner_byte_sum,
	output logic [pomc_pkg::TOT_W-1:0]        visited_pages,
	output logic [pomc_pkg::BYTE_W-1:0]       visited_bytes,
	output logic                              run_end
);

	pomc_pkg::pomc_cmd_t  cmd;
	pomc_pkg::pomc_stat_t stat;

	// Register writes are always accepted
	assign cfg_ready = 1'b1;

	pomc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pomc_datapath #(
		.MAP_PAGES   (MAP_PAGES),
		.OWNER_SLOTS (OWNER_SLOTS),
		.MAX_RUN     (MAX_RUN)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.first_page       (first_page),
		.page_run         (page_run),
		.owner_index      (owner_index),
		.payload_size     (payload_size),
		.header_size      (header_size),
		.page_number      (page_number),
		.page_status      (page_status),
		.prior_owner      (prior_owner),
		.size_status      (size_status),
		.owner_page_count (owner_page_count),
		.owner_byte_sum   (owner_byte_sum),
		.visited_pages    (visited_pages),
		.visited_bytes    (visited_bytes),
		.run_end          (run_end)
	);

	// A run with pages keeps the input closed on the next cycle
	`POMC_CHECK_NEXT(a_busy_after_run, in_valid && in_ready && (page_run != '0), !in_ready)
	// A page flagged as owned always names its owner
	`POMC_CHECK_NOW(a_owned_has_prior, out_valid && (page_status == pomc_pkg::PAGE_OWNED), prior_owner != '0)
	// Only owned pages report a prior owner
	`POMC_CHECK_NOW(a_prior_only_owned, out_valid && (page_status != pomc_pkg::PAGE_OWNED), prior_owner == '0)
	// A claim always leaves the owner with at least one page
	`POMC_CHECK_NOW(a_claim_counts, out_valid && (page_status == pomc_pkg::PAGE_CLAIMED), owner_page_count != '0)

endmodule

/* dv/page_ownership_map_checker_test.sv */
module page_ownership_map_checker_test;
	import pomc_pkg::*;

	// Saturation ceilings and timing bounds
	localparam longint unsigned PAGES_TOP   = 64'hFFFF_FFFF;
	localparam longint unsigned BYTES_TOP   = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned COUNT_TOP   = 64'h1_FFFF;
	localparam int unsigned     RUN_LATENCY = 3 + 2 * MAX_RUN_DEF + 8;
	localparam int unsigned     QUIET_LIMIT = 200000;

	// One visited page run as sent to the block
	typedef struct {
		logic [PAGE_W-1:0]  first;
		logic [RUN_W-1:0]   len;
		logic [OWNER_W-1:0] who;
		logic [PAY_W-1:0]   payload;
		logic [HDR_W-1:0]   header;
	} run_item_t;

	// One per-page result beat
	typedef struct {
		logic [PAGE_W-1:0]  page;
		page_stat_t         pstat;
		logic [OWNER_W-1:0] prior;
		size_stat_t         sstat;
		logic [CNT_W-1:0]   opages;
		logic [BYTE_W-1:0]  obytes;
		logic [TOT_W-1:0]   vpages;
		logic [BYTE_W-1:0]  vbytes;
		logic               last;
	} page_beat_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PAGE_SIZE;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [PAGE_W-1:0]  first_page = '0;
	logic [RUN_W-1:0]   page_run = '0;
	logic [OWNER_W-1:0] owner_index = '0;
	logic [PAY_W-1:0]   payload_size = '0;
	logic [HDR_W-1:0]   header_size = '0;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PAGE_W-1:0]  page_number;
	logic [1:0]         page_status;
	logic [OWNER_W-1:0] prior_owner;
	logic [1:0]         size_status;
	logic [CNT_W-1:0]   owner_page_count;
	logic [BYTE_W-1:0]  owner_byte_sum;
	logic [TOT_W-1:0]   visited_pages;
	logic [BYTE_W-1:0]  visited_bytes;
	logic               run_end;

	// Shadow of the block's state and registers
	logic [CFG_W-1:0]   cfg_page_size = PAGE_SIZE_RST;
	logic [CFG_W-1:0]   cfg_page_limit = PAGE_LIMIT_RST;
	logic [OWNER_W-1:0] page_owner [MAP_PAGES_DEF];
	logic [CNT_W-1:0]   slot_pages [OWNER_SLOTS_DEF];
	logic [BYTE_W-1:0]  slot_bytes [OWNER_SLOTS_DEF];
	logic [TOT_W-1:0]   pages_seen;
	logic [BYTE_W-1:0]  bytes_seen;

	run_item_t  run_queue [$];
	page_beat_t owed_beats [$];
	page_beat_t next_beat;
	run_item_t  cur_run;

	bit          gaps_on = 1'b0;
	bit          stalls_on = 1'b0;
	bit          in_taken = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned quiet = 0;
	int unsigned mismatches = 0;
	int unsigned runs_taken = 0;
	int unsigned beats_checked = 0;
	int unsigned status_tally [3] = '{0, 0, 0};
	int unsigned size_tally [4] = '{0, 0, 0, 0};

	page_ownership_map_checker dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.first_page       (first_page),
		.page_run         (page_run),
		.owner_index      (owner_index),
		.payload_size     (payload_size),
		.header_size      (header_size),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.page_number      (page_number),
		.page_status      (page_status),
		.prior_owner      (prior_owner),
		.size_status      (size_status),
		.owner_page_count (owner_page_count),
		.owner_byte_sum   (owner_byte_sum),
		.visited_pages    (visited_pages),
		.visited_bytes    (visited_bytes),
		.run_end          (run_end)
	);

	// Clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint unsigned sat_sum(input longint unsigned a, input longint unsigned b,
			input longint unsigned top);
		return (a + b >= top) ? top : a + b;
	endfunction

	// Idle length: mostly short, now and then long
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Walk one run through the shadow state and queue the beats it owes
	task automatic account_run(input run_item_t it);
		longint unsigned len;
		longint unsigned bytes_in;
		int unsigned     who;
		int unsigned     k;
		logic [PAGE_W-1:0] pg;
		size_stat_t      sstat;
		page_beat_t      b;
		if (it.len == 0)
			return;
		len = (it.len > MAX_RUN_DEF) ? MAX_RUN_DEF : it.len;
		who = it.who % OWNER_SLOTS_DEF;
		pages_seen = sat_sum(pages_seen, len, PAGES_TOP);
		bytes_in = longint'(it.payload) + longint'(it.header);
		// header first, then empty payload, then overflow of the run
		if (it.header < LONG_BYTES || longint'(it.header) + LONG_BYTES >= cfg_page_size) begin
			sstat = SIZE_BAD_HDR;
		end else if (it.payload == 0) begin
			sstat = SIZE_EMPTY;
		end else if (bytes_in > len * cfg_page_size) begin
			sstat = SIZE_OVER;
		end else begin
			sstat = SIZE_GOOD;
			slot_bytes[who] = sat_sum(slot_bytes[who], bytes_in, BYTES_TOP);
			bytes_seen = sat_sum(bytes_seen, bytes_in, BYTES_TOP);
		end
		pg = it.first;
		for (k = 0; k < len; k++) begin
			b.prior = '0;
			if (pg >= cfg_page_limit || pg >= MAP_PAGES_DEF) begin
				b.pstat = PAGE_RANGE;
			end else if (page_owner[pg] != 0) begin
				b.pstat = PAGE_OWNED;
				b.prior = page_owner[pg];
			end else begin
				// owner zero leaves the page unowned but is still credited
				b.pstat = PAGE_CLAIMED;
				page_owner[pg] = who;
				slot_pages[who] = sat_sum(slot_pages[who], 1, COUNT_TOP);
			end
			b.page   = pg;
			b.sstat  = sstat;
			b.opages = slot_pages[who];
			b.obytes = slot_bytes[who];
			b.vpages = pages_seen;
			b.vbytes = bytes_seen;
			b.last   = (k + 1 == len);
			owed_beats.push_back(b);
			pg = pg + 1'b1;
		end
	endtask

	// Random run, mostly well formed for the current register setting
	function automatic run_item_t make_random_run();
		run_item_t       it;
		int unsigned     pick;
		int unsigned     eff_len;
		int unsigned     hdr_top;
		longint unsigned room;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			it.first = $urandom_range(0, 1023);
		else if (pick < 75)
			it.first = $urandom_range(0, MAP_PAGES_DEF - 1);
		else if (pick < 85)
			it.first = 32'hFFFF_FFFF - $urandom_range(0, 70);
		else
			it.first = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 55)
			it.len = 1;
		else if (pick < 80)
			it.len = $urandom_range(2, 8);
		else if (pick < 92)
			it.len = $urandom_range(9, MAX_RUN_DEF);
		else if (pick < 97)
			it.len = $urandom_range(MAX_RUN_DEF + 1, 127);
		else
			it.len = 0;
		it.who = $urandom_range(0, 63);
		eff_len = (it.len > MAX_RUN_DEF) ? MAX_RUN_DEF : it.len;
		if (cfg_page_size >= 2 * LONG_BYTES + 1 && $urandom_range(0, 3) != 0) begin
			hdr_top = cfg_page_size - LONG_BYTES - 1;
			if (hdr_top > 65535)
				hdr_top = 65535;
			it.header = $urandom_range(LONG_BYTES, hdr_top);
		end else begin
			it.header = $urandom_range(0, 65535);
		end
		room = longint'(eff_len) * cfg_page_size;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			it.payload = '0;
		end else if (pick < 75 && room > it.header) begin
			room = room - it.header;
			if (room > 22'h3F_FFFF)
				room = 22'h3F_FFFF;
			it.payload = $urandom_range(1, room);
		end else begin
			it.payload = $urandom_range(0, 22'h3F_FFFF);
		end
		return it;
	endfunction

	task automatic queue_run(input logic [PAGE_W-1:0] first, input logic [RUN_W-1:0] len,
			input logic [OWNER_W-1:0] who, input logic [PAY_W-1:0] payload,
			input logic [HDR_W-1:0] header);
		run_item_t it;
		it.first   = first;
		it.len     = len;
		it.who     = who;
		it.payload = payload;
		it.header  = header;
		run_queue.push_back(it);
	endtask

	task automatic queue_random(input int unsigned count);
		repeat (count) run_queue.push_back(make_random_run());
	endtask

	// Register write; only issued while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_PAGE_SIZE)
			cfg_page_size = value;
		else
			cfg_page_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold off until every owed beat is back, then let a trailing run finish
	task automatic settle();
		while (run_queue.size() != 0 || in_valid || owed_beats.size() != 0)
			@(posedge clk);
		repeat (RUN_LATENCY) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Input driver: accept at the rising edge, next beat at the falling edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			account_run(cur_run);
			runs_taken++;
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (run_queue.size() > 0) begin
				cur_run = run_queue.pop_front();
				first_page   <= cur_run.first;
				page_run     <= cur_run.len;
				owner_index  <= cur_run.who;
				payload_size <= cur_run.payload;
				header_size  <= cur_run.header;
				in_valid     <= 1'b1;
				gap_left = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (stalls_on && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left = idle_len() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (owed_beats.size() == 0) begin
				$error("beat for page 'h%0h with none owed", page_number);
				mismatches++;
			end else begin
				next_beat = owed_beats.pop_front();
				check_field("page_number", next_beat.page, page_number);
				check_field("page_status", next_beat.pstat, page_status);
				check_field("prior_owner", next_beat.prior, prior_owner);
				check_field("size_status", next_beat.sstat, size_status);
				check_field("owner_page_count", next_beat.opages, owner_page_count);
				check_field("owner_byte_sum", next_beat.obytes, owner_byte_sum);
				check_field("visited_pages", next_beat.vpages, visited_pages);
				check_field("visited_bytes", next_beat.vbytes, visited_bytes);
				check_field("run_end", next_beat.last, run_end);
				status_tally[int'(next_beat.pstat)]++;
				size_tally[int'(next_beat.sstat)]++;
				beats_checked++;
			end
		end
	end

	// Watchdog on cycles with no beat on any channel (covers the clearing sweep)
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no progress for %0d cycles, %0d beats owed", quiet,
					owed_beats.size());
				$display("[page_ownership_map_checker] ERROR");
				$finish;
			end
		end
	end

	// Stimulus sequence
	initial begin
		foreach (page_owner[i])
			page_owner[i] = '0;
		foreach (slot_pages[i]) begin
			slot_pages[i] = '0;
			slot_bytes[i] = '0;
		end
		pages_seen = '0;
		bytes_seen = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed runs at reset settings, no idling
		queue_run(0, 1, 1, 100, LONG_BYTES);
		queue_run(0, 1, 2, 100, LONG_BYTES);
		queue_run(5, 0, 3, 100, 20);
		queue_run(1, 1, 3, 100, LONG_BYTES - 1);
		queue_run(2, 1, 3, 100, 4096 - LONG_BYTES - 1);
		queue_run(3, 1, 3, 100, 4096 - LONG_BYTES);
		queue_run(4, 1, 4, 0, 100);
		queue_run(5, 1, 4, 4089, LONG_BYTES);
		queue_run(6, 1, 4, 4088, LONG_BYTES);
		queue_run(100, 127, 5, 200000, 64);
		queue_run(MAP_PAGES_DEF - 1, 2, 6, 1000, 16);
		queue_run(32'hFFFF_FFFE, 4, 7, 1000, 16);
		queue_run(500, 2, 0, 1000, 16);
		queue_run(500, 2, 0, 1000, 16);
		queue_run(1000, MAX_RUN_DEF, 63, 22'h3F_FFFF, 16'hFFFF);
		queue_run(2000, MAX_RUN_DEF, 8, 22'h3F_FFFF, 100);
		queue_run(32'hFFFF_FFFF, 1, 9, 50, LONG_BYTES);
		queue_run(100, 3, 10, 300, 30);
		queue_run(4000, 127, 63, 1, LONG_BYTES);
		settle();

		// Page size of 256, no valid pages at all
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		write_reg(CFG_PAGE_SIZE, 17'd256);
		write_reg(CFG_PAGE_LIMIT, 17'd0);
		queue_random(10);
		settle();

		// Page size of 65536, full map
		write_reg(CFG_PAGE_SIZE, 17'd65536);
		write_reg(CFG_PAGE_LIMIT, 17'd65536);
		queue_random(45);
		settle();

		// Register extremes, sender without gaps
		gaps_on = 1'b0;
		write_reg(CFG_PAGE_SIZE, 17'h1_FFFF);
		write_reg(CFG_PAGE_LIMIT, 17'h1_FFFF);
		queue_run(3000, 1, 11, 50000, 16'hFFFF);
		queue_run(3001, 33, 12, 22'h3F_FFFF, 16'hFFFF);
		queue_random(35);
		settle();

		// Page size below the smallest header: every header is bad
		gaps_on = 1'b1;
		write_reg(CFG_PAGE_SIZE, $urandom_range(0, LONG_BYTES - 1));
		write_reg(CFG_PAGE_LIMIT, 17'd1000);
		queue_random(15);
		settle();

		// Usual page size with a random limit
		write_reg(CFG_PAGE_SIZE, 17'd4096);
		write_reg(CFG_PAGE_LIMIT, $urandom_range(256, MAP_PAGES_DEF));
		queue_random(45);
		settle();

		$display("%0d runs over six register settings, %0d page beats checked", runs_taken,
			beats_checked);
		$display("pages claimed %0d / out of range %0d / already owned %0d; sizes good %0d, "
			, status_tally[0], status_tally[1], status_tally[2], size_tally[0],
			"bad header %0d, empty %0d, overflowed %0d", size_tally[1], size_tally[2],
			size_tally[3]);
		if (mismatches == 0)
			$display("[page_ownership_map_checker] OK");
		else
			$display("[page_ownership_map_checker] ERROR");
		$finish;
	end

endmodule
